// ----- hdl/pcm_mixer_with_count_attenuation_macros.svh -----
// Assertion macros for the PCM mixer checker.
// Each macro expects aclk and aresetn in scope.
`ifndef PCM_MIXER_WITH_COUNT_ATTENUATION_MACROS_SVH
`define PCM_MIXER_WITH_COUNT_ATTENUATION_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PCMMIX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcmmix check failed");

// antecedent implies consequent in the next cycle
`define PCMMIX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcmmix check failed");

// signal holds while a transfer is stalled
`define PCMMIX_ASSERT_HOLD(lbl, vld, rdy, sig) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        ((vld) && !(rdy)) |=> $stable(sig)) else $error("pcmmix stalled value moved");

`endif

// ----- hdl/pcmmix_pkg.sv -----
// Shared types and constants for the PCM mixer.
// No dependencies.
`default_nettype none
package pcmmix_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int BYTE_W        = 8;
    localparam int GAIN_W        = 8;
    localparam int CNT_W         = 4;
    localparam int SHIFT_W       = 2;
    localparam int NUM_LANES     = 8;
    localparam int MAX_LANES_DEF = 8;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CNT_W-1:0]  ACTIVE_RST = CNT_W'(0);
    localparam logic              FORMAT_RST = 1'b1;
    localparam logic [GAIN_W-1:0] GAIN3_RST  = GAIN_W'(85);
    localparam logic [GAIN_W-1:0] GAIN5_RST  = GAIN_W'(51);

    // silence level of unsigned 8-bit samples
    localparam logic [SAMPLE_W-1:0] SILENCE_U8 = SAMPLE_W'(128);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ACTIVE = 2'd0,
        CFG_FORMAT = 2'd1,
        CFG_GAIN3  = 2'd2,
        CFG_GAIN5  = 2'd3
    } cfg_idx_e;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic               wide;
        logic               use_mul;
        logic [GAIN_W-1:0]  gain;
        logic [SHIFT_W-1:0] shift;
    } mix_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/pcm_mixer_with_count_attenuation.sv -----
// PCM mixer: sums one sample position of up to eight streams, attenuated by
// stream count (shift, or gain multiply for three and five streams), in
// unsigned 8-bit or signed 16-bit form. Accepts one sample position per cycle
// while m_ready does not hold the pipeline, through registered stages: input
// register, per-lane multiply/shift, pair adds, final add into the output
// register. Each stage holds under back-pressure and fills bubbles on its own.
// Write configuration only while the pipeline is empty.
`default_nettype none
module pcm_mixer_with_count_attenuation #(
    parameter int MAX_LANES = pcmmix_pkg::MAX_LANES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [pcmmix_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [pcmmix_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pcmmix_pkg::SAMPLE_W-1:0]     s_lane_0,
    input  logic [pcmmix_pkg::SAMPLE_W-1:0]     s_lane_1,
    input  logic [pcmmix_pkg::SAMPLE_W-1:0]     s_lane_2,
    input  logic [pcmmix_pkg::SAMPLE_W-1:0]     s_lane_3,
    input  logic [pcmmix_pkg::SAMPLE_W-1:0]     s_lane_4,
    input  logic [pcmmix_pkg::SAMPLE_W-1:0]     s_lane_5,
    input  logic [pcmmix_pkg::SAMPLE_W-1:0]     s_lane_6,
    input  logic [pcmmix_pkg::SAMPLE_W-1:0]     s_lane_7,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [pcmmix_pkg::SAMPLE_W-1:0]     m_mixed_sample
);
    import pcmmix_pkg::*;

    logic [CNT_W-1:0]  active_reg;
    logic              format_reg;
    logic [GAIN_W-1:0] gain3_reg;
    logic [GAIN_W-1:0] gain5_reg;

    mix_ctrl_t ctrl;
    logic [NUM_LANES-1:0] lane_on;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;

    sample_t in_lanes [NUM_LANES];
    sample_t lane_reg [NUM_LANES];
    sample_t terms    [NUM_LANES];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RST;
            format_reg <= FORMAT_RST;
            gain3_reg  <= GAIN3_RST;
            gain5_reg  <= GAIN5_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_e'(cfg_addr))
                CFG_ACTIVE: active_reg <= cfg_wdata[CNT_W-1:0];
                CFG_FORMAT: format_reg <= cfg_wdata[0];
                CFG_GAIN3:  gain3_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_GAIN5:  gain5_reg  <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // attenuation chosen by stream count
    always_comb begin
        ctrl.wide    = format_reg;
        ctrl.use_mul = 1'b0;
        ctrl.gain    = '0;
        case (active_reg)
            4'd0, 4'd1: ctrl.shift = SHIFT_W'(0);
            4'd2:       ctrl.shift = SHIFT_W'(1);
            4'd3: begin
                ctrl.shift   = SHIFT_W'(0);
                ctrl.use_mul = 1'b1;
                ctrl.gain    = gain3_reg;
            end
            4'd4:       ctrl.shift = SHIFT_W'(2);
            4'd5: begin
                ctrl.shift   = SHIFT_W'(0);
                ctrl.use_mul = 1'b1;
                ctrl.gain    = gain5_reg;
            end
            default:    ctrl.shift = SHIFT_W'(3);
        endcase
    end

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_on[i] = (i < MAX_LANES) && (active_reg > CNT_W'(i));
        end
    end

    // per-stage ready: a stage loads when empty or when its result moves on
    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    assign v1_next = rdy1 ? s_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg  : v2_reg;
    assign v3_next = rdy3 ? v2_reg  : v3_reg;
    assign v4_next = rdy4 ? v3_reg  : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign in_lanes[0] = s_lane_0;
    assign in_lanes[1] = s_lane_1;
    assign in_lanes[2] = s_lane_2;
    assign in_lanes[3] = s_lane_3;
    assign in_lanes[4] = s_lane_4;
    assign in_lanes[5] = s_lane_5;
    assign in_lanes[6] = s_lane_6;
    assign in_lanes[7] = s_lane_7;

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            for (int i = 0; i < NUM_LANES; i++) begin
                lane_reg[i] <= in_lanes[i];
            end
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        pcmmix_term u_term (
            .aclk     (aclk),
            .load     (rdy2 && v1_reg),
            .lane_on  (lane_on[g]),
            .ctrl     (ctrl),
            .raw      (lane_reg[g]),
            .term_reg (terms[g])
        );
    end

    pcmmix_tree u_tree (
        .aclk      (aclk),
        .load_pair (rdy3 && v2_reg),
        .load_out  (rdy4 && v3_reg),
        .wide      (format_reg),
        .terms     (terms),
        .sum_reg   (m_mixed_sample)
    );

    assign m_valid = v4_reg;

endmodule
`default_nettype wire

// ----- hdl/pcmmix_term.sv -----
// One lane's attenuation cell: gain multiply or shift (zero when the lane is off), registered.
// Depends on pcmmix_pkg.
`default_nettype none
module pcmmix_term (
    input  logic                 aclk,
    input  logic                 load,
    input  logic                 lane_on,
    input  pcmmix_pkg::mix_ctrl_t ctrl,
    input  pcmmix_pkg::sample_t  raw,
    output pcmmix_pkg::sample_t  term_reg
);
    import pcmmix_pkg::*;

    logic signed [SAMPLE_W:0]          operand;
    logic signed [SAMPLE_W+GAIN_W+1:0] product;
    logic signed [SAMPLE_W:0]          shifted;
    sample_t                           term_next;

    always_comb begin
        // 8-bit samples are zero extended so one datapath serves both modes
        operand = ctrl.wide ? {raw[SAMPLE_W-1], raw}
                            : {{(SAMPLE_W-BYTE_W+1){1'b0}}, raw[BYTE_W-1:0]};
        product = operand * $signed({1'b0, ctrl.gain});
        shifted = operand >>> ctrl.shift;
        if (!lane_on) begin
            term_next = '0;
        end else if (ctrl.use_mul) begin
            term_next = product[GAIN_W +: SAMPLE_W];
        end else begin
            term_next = shifted[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            term_reg <= term_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/pcmmix_tree.sv -----
// Two-level registered adder tree: pair sums, then final sum with silence offset in 8-bit mode.
// Depends on pcmmix_pkg.
`default_nettype none
module pcmmix_tree (
    input  logic                aclk,
    input  logic                load_pair,
    input  logic                load_out,
    input  logic                wide,
    input  pcmmix_pkg::sample_t terms [pcmmix_pkg::NUM_LANES],
    output pcmmix_pkg::sample_t sum_reg
);
    import pcmmix_pkg::*;

    localparam int PAIRS = NUM_LANES / 2;

    sample_t pair_reg  [PAIRS];
    sample_t pair_next [PAIRS];
    sample_t sum_next;
    sample_t acc;

    always_comb begin
        for (int i = 0; i < PAIRS; i++) begin
            pair_next[i] = terms[2*i] + terms[2*i+1];
        end
        acc = wide ? '0 : SILENCE_U8;
        for (int i = 0; i < PAIRS; i++) begin
            acc = acc + pair_reg[i];
        end
        // 8-bit mode wraps modulo 256
        sum_next = wide ? acc : {{(SAMPLE_W-BYTE_W){1'b0}}, acc[BYTE_W-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (load_pair) begin
            for (int i = 0; i < PAIRS; i++) begin
                pair_reg[i] <= pair_next[i];
            end
        end
        if (load_out) begin
            sum_reg <= sum_next;
        end
    end

endmodule
`default_nettype wire

// ----- hdl/pcmmix_checker.sv -----
// Port-level checker for the PCM mixer, bound to the top level.
// Depends on pcmmix_pkg and pcm_mixer_with_count_attenuation_macros.svh.
`default_nettype none
`include "pcm_mixer_with_count_attenuation_macros.svh"
module pcmmix_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              cfg_wr_en,
    input logic [pcmmix_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input logic [pcmmix_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [pcmmix_pkg::SAMPLE_W-1:0]   m_mixed_sample
);
    import pcmmix_pkg::*;

    // shadow of the sample format register
    logic fmt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FORMAT_RST;
        end else if (cfg_wr_en && (cfg_idx_e'(cfg_addr) == CFG_FORMAT)) begin
            fmt_reg <= cfg_wdata[0];
        end
    end

    `PCMMIX_ASSERT_NEXT(a_valid_holds, m_valid && !m_ready, m_valid)
    `PCMMIX_ASSERT_HOLD(a_data_holds, m_valid, m_ready, m_mixed_sample)
    `PCMMIX_ASSERT_NOW(a_empty_accepts, !m_valid, s_ready)
    `PCMMIX_ASSERT_NOW(a_byte_upper_zero, m_valid && !fmt_reg, m_mixed_sample[SAMPLE_W-1:BYTE_W] == '0)

endmodule

bind pcm_mixer_with_count_attenuation pcmmix_checker u_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_mixed_sample (m_mixed_sample)
);
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for the PCM mixer: directed and random sample positions, checked
// against an in-bench prediction of the attenuated, wrapped mix.
// Depends on pcmmix_pkg and pcm_mixer_with_count_attenuation.
module tb;
    import pcmmix_pkg::*;

    localparam int STALL_LIMIT    = 5000;
    localparam int RX_HOLD_CYCLES = 80;
    localparam int PIPE_SETTLE    = 6;
    localparam int MAX_REPORTS    = 40;
    localparam sample_t NARROW_MASK = 16'h00ff;

    typedef sample_t mix_lanes_t [NUM_LANES];

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    sample_t s_lane_0 = '0, s_lane_1 = '0, s_lane_2 = '0, s_lane_3 = '0;
    sample_t s_lane_4 = '0, s_lane_5 = '0, s_lane_6 = '0, s_lane_7 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    sample_t m_mixed_sample;

    // mirrored mixer settings
    logic [CNT_W-1:0]  cfg_active = ACTIVE_RST;
    logic              cfg_wide   = FORMAT_RST;
    logic [GAIN_W-1:0] cfg_gain3  = GAIN3_RST;
    logic [GAIN_W-1:0] cfg_gain5  = GAIN5_RST;

    sample_t mix_expect_q[$];
    int      mix_errors   = 0;
    int      idle_cycles  = 0;
    bit      no_idle      = 1'b0;
    bit      rx_hold_req  = 1'b0;

    always #1 aclk = ~aclk;

    pcm_mixer_with_count_attenuation i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_lane_0       (s_lane_0),
        .s_lane_1       (s_lane_1),
        .s_lane_2       (s_lane_2),
        .s_lane_3       (s_lane_3),
        .s_lane_4       (s_lane_4),
        .s_lane_5       (s_lane_5),
        .s_lane_6       (s_lane_6),
        .s_lane_7       (s_lane_7),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mixed_sample (m_mixed_sample)
    );

    function automatic sample_t mix_predict(input mix_lanes_t lanes);
        int unsigned shamt;
        int unsigned n_lanes;
        logic        use_gain;
        logic [7:0]  gain;
        sample_t     acc;
        sample_t     term;
        sample_t     w;
        logic [7:0]  b;
        logic [31:0] prod;
        use_gain = 1'b0;
        gain = '0;
        shamt = 0;
        case (cfg_active)
            4'd0, 4'd1: shamt = 0;
            4'd2: shamt = 1;
            4'd3: begin
                use_gain = 1'b1;
                gain = cfg_gain3;
            end
            4'd4: shamt = 2;
            4'd5: begin
                use_gain = 1'b1;
                gain = cfg_gain5;
            end
            default: shamt = 3;
        endcase
        n_lanes = (cfg_active < NUM_LANES) ? cfg_active : NUM_LANES;
        acc = cfg_wide ? '0 : SILENCE_U8;
        for (int i = 0; i < n_lanes; i++) begin
            if (cfg_wide) begin
                w = lanes[i];
                if (use_gain) begin
                    // sign-extended sample times gain, bits 23:8
                    prod = {{16{w[15]}}, w} * {24'd0, gain};
                    term = prod[23:8];
                end else begin
                    term = $signed(w) >>> shamt;
                end
                acc = acc + term;
            end else begin
                b = lanes[i][7:0];
                if (use_gain) begin
                    prod = {24'd0, b} * {24'd0, gain};
                    term = {8'd0, prod[15:8]};
                end else begin
                    term = {8'd0, b >> shamt};
                end
                acc = (acc + term) & NARROW_MASK;
            end
        end
        return acc;
    endfunction

    function automatic sample_t rand_sample();
        sample_t v;
        v = 16'($urandom);
        if ($urandom_range(99) < 25) begin
            case ($urandom_range(5))
                0: v = 16'h0000;
                1: v = 16'h7fff;
                2: v = 16'h8000;
                3: v = 16'hffff;
                4: v = 16'h00ff;
                default: v = 16'h0080;
            endcase
        end
        return v;
    endfunction

    function automatic mix_lanes_t fill_lanes(input sample_t v);
        mix_lanes_t lanes;
        foreach (lanes[i]) lanes[i] = v;
        return lanes;
    endfunction

    task automatic send_mix(input mix_lanes_t lanes);
        if (!no_idle && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_lane_0 <= lanes[0];
        s_lane_1 <= lanes[1];
        s_lane_2 <= lanes[2];
        s_lane_3 <= lanes[3];
        s_lane_4 <= lanes[4];
        s_lane_5 <= lanes[5];
        s_lane_6 <= lanes[6];
        s_lane_7 <= lanes[7];
        s_valid  <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        mix_expect_q.push_back(mix_predict(lanes));
    endtask

    // stop offering and let every outstanding result come out
    task automatic drain_results();
        s_valid <= 1'b0;
        while (mix_expect_q.size() != 0) @(posedge aclk);
        repeat (PIPE_SETTLE) @(posedge aclk);
    endtask

    task automatic set_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
        cfg_addr  <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        case (idx)
            CFG_ACTIVE: cfg_active = val[CNT_W-1:0];
            CFG_FORMAT: cfg_wide   = val[0];
            CFG_GAIN3:  cfg_gain3  = val;
            CFG_GAIN5:  cfg_gain5  = val;
            default: ;
        endcase
    endtask

    task automatic apply_config(input int active, input bit wide,
                                input int gain3, input int gain5);
        drain_results();
        set_reg(CFG_ACTIVE, 8'(active));
        set_reg(CFG_FORMAT, 8'(wide));
        set_reg(CFG_GAIN3, 8'(gain3));
        set_reg(CFG_GAIN5, 8'(gain5));
        cfg_wr_en <= 1'b0;
    endtask

    // defaults after reset: no lanes, then the default gains via count only
    task automatic test_reset_values();
        mix_lanes_t lanes;
        lanes = fill_lanes(16'h1234);
        send_mix(lanes);
        drain_results();
        set_reg(CFG_ACTIVE, 8'd3);
        cfg_wr_en <= 1'b0;
        send_mix(fill_lanes(16'h8000));
        send_mix(lanes);
        drain_results();
        set_reg(CFG_ACTIVE, 8'd5);
        cfg_wr_en <= 1'b0;
        send_mix(fill_lanes(16'h7fff));
    endtask

    task automatic test_wide_extremes();
        mix_lanes_t lanes;
        apply_config(1, 1'b1, 85, 51);
        send_mix(fill_lanes(16'h8000));
        apply_config(8, 1'b1, 85, 51);
        send_mix(fill_lanes(16'h7fff));
        apply_config(2, 1'b1, 85, 51);
        send_mix(fill_lanes(16'hffff));
        // inactive lanes carry junk that must not leak in
        lanes = fill_lanes(16'h7fff);
        lanes[0] = 16'h8000;
        lanes[1] = 16'h8001;
        send_mix(lanes);
        apply_config(4, 1'b1, 85, 51);
        send_mix(fill_lanes(16'h8000));
        apply_config(6, 1'b1, 85, 51);
        send_mix(fill_lanes(16'hffff));
        apply_config(15, 1'b1, 85, 51);
        send_mix(fill_lanes(16'h8001));
        apply_config(3, 1'b1, 0, 255);
        send_mix(fill_lanes(16'h8000));
        apply_config(5, 1'b1, 0, 255);
        send_mix(fill_lanes(16'h8000));
    endtask

    task automatic test_narrow_extremes();
        apply_config(0, 1'b0, 85, 51);
        send_mix(fill_lanes(16'hffff));
        apply_config(1, 1'b0, 85, 51);
        send_mix(fill_lanes(16'h00ff));
        apply_config(2, 1'b0, 85, 51);
        send_mix(fill_lanes(16'hff80));
        apply_config(3, 1'b0, 255, 0);
        send_mix(fill_lanes(16'h00ff));
        apply_config(5, 1'b0, 255, 0);
        send_mix(fill_lanes(16'h00ff));
        apply_config(8, 1'b0, 255, 255);
        send_mix(fill_lanes(16'h00ff));
        apply_config(12, 1'b0, 255, 255);
        send_mix(fill_lanes(16'hab7f));
    endtask

    // receiver stops while the sender keeps offering back to back
    task automatic test_backpressure();
        mix_lanes_t lanes;
        apply_config(8, 1'b1, $urandom_range(255), $urandom_range(255));
        no_idle = 1'b1;
        rx_hold_req = 1'b1;
        repeat (48) begin
            foreach (lanes[i]) lanes[i] = rand_sample();
            send_mix(lanes);
        end
        drain_results();
        no_idle = 1'b0;
    endtask

    task automatic test_random_mix();
        mix_lanes_t lanes;
        int n_items;
        int active;
        int gain3;
        int gain5;
        for (int phase = 0; phase < 20; phase++) begin
            active = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(15, 9);
            gain3 = $urandom_range(255);
            gain5 = $urandom_range(255);
            if ($urandom_range(9) == 0) gain3 = 0;
            if ($urandom_range(9) == 0) gain5 = 255;
            apply_config(active, 1'($urandom_range(1)), gain3, gain5);
            n_items = 80;
            if (phase == 4) begin
                no_idle = 1'b1;
                n_items = 300;
            end
            repeat (n_items) begin
                foreach (lanes[i]) lanes[i] = rand_sample();
                send_mix(lanes);
            end
            no_idle = 1'b0;
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_wide_extremes();
        test_narrow_extremes();
        test_backpressure();
        test_random_mix();
        drain_results();
        repeat (4) @(posedge aclk);
        if (mix_errors == 0 && mix_expect_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // receiver side: random idling, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= no_idle || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge aclk) begin
        sample_t expected;
        if (aresetn && m_valid && m_ready) begin
            if (mix_expect_q.size() == 0) begin
                mix_errors++;
                if (mix_errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_mixed_sample);
            end else begin
                expected = mix_expect_q.pop_front();
                if (m_mixed_sample !== expected) begin
                    mix_errors++;
                    if (mix_errors <= MAX_REPORTS)
                        $display("%0t: mixed_sample mismatch, expected %h, actual %h",
                                 $time, expected, m_mixed_sample);
                end
            end
        end
    end

    // count cycles without any transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
